// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define HRS_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: %m");
// Check that a consequent holds in the cycle of its antecedent.
`define HRS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");
// Check that a consequent holds in the cycle after its antecedent.
`define HRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");
`else
`define HRS_ASSERT_ALWAYS(label, expr)
`define HRS_ASSERT_SAME(label, ante, cons)
`define HRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/hrs_pkg.sv =====
// Types and constants of the horizontal area resampler.
`default_nettype none
package hrs_pkg;
	localparam int PIX_W        = 8;
	localparam int WIDTH_W      = 13;
	localparam int CHAN_W       = 3;
	localparam int SUM_W        = 20;
	localparam int NUM_CH       = 4;
	localparam int CH_IDX_W     = 2;
	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int DIV_STEPS    = SUM_W / 2;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd2;

	typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_t;

	typedef struct packed {
		logic               ok;
		logic [WIDTH_W-1:0] src_width;
		logic [WIDTH_W-1:0] dst_width;
		logic [CHAN_W-1:0]  channels;
	} cfg_t;

	typedef struct packed {
		logic               go;
		logic [WIDTH_W-1:0] src_width;
	} restart_t;

	typedef struct packed {
		logic     valid;
		logic     last;
		pix_vec_t ch;
	} result_t;
endpackage
`default_nettype wire

// ===== design/hrs_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
`default_nettype none
module hrs_div import hrs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SUM_W-1:0]   dividend,
	input  wire logic [WIDTH_W-1:0] divisor,
	output logic                    done,
	output logic [PIX_W-1:0]        quotient
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     num_q;
	logic [WIDTH_W-1:0]   rem_q;
	logic [PIX_W-1:0]     quo_q;

	logic [WIDTH_W:0]   div_ext;
	logic [WIDTH_W:0]   t1;
	logic [WIDTH_W:0]   t2;
	logic               ge1;
	logic               ge2;
	logic [WIDTH_W-1:0] r1;
	logic [WIDTH_W-1:0] r2;

	always_comb begin
		div_ext = {1'b0, divisor};
		t1  = {rem_q, num_q[SUM_W-1]};
		ge1 = t1 >= div_ext;
		r1  = ge1 ? WIDTH_W'(t1 - div_ext) : t1[WIDTH_W-1:0];
		t2  = {r1, num_q[SUM_W-2]};
		ge2 = t2 >= div_ext;
		r2  = ge2 ? WIDTH_W'(t2 - div_ext) : t2[WIDTH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-3:0], 2'b00};
			rem_q <= r2;
			quo_q <= {quo_q[PIX_W-3:0], ge1, ge2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== design/hrs_seq.sv =====
// Sequencer and accumulators: shared multiply-add feeding the shared divider.
`default_nettype none
module hrs_seq import hrs_pkg::*; #(
	parameter int MAX_RUN = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire restart_t restart,
	input  wire logic     in_valid,
	input  wire pix_vec_t in_pix,
	output logic          in_stall,
	input  wire logic     out_free,
	output result_t       emit
);
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_MAC    = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_REM    = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [CH_IDX_W-1:0]             ch_q;
	logic [RUN_W-1:0]                cnt_q;
	logic [WIDTH_W-1:0]              span_q;
	logic [WIDTH_W-1:0]              left_q;
	logic [NUM_CH-1:0][SUM_W-1:0]    sums_q;
	pix_vec_t                        px_q;
	pix_vec_t                        res_q;

	logic                      accept;
	logic                      last_ch;
	logic [WIDTH_W-1:0]        mul_sel;
	logic [WIDTH_W+PIX_W-1:0]  prod;
	logic [SUM_W-1:0]          mac;
	logic                      div_done;
	logic [PIX_W-1:0]          div_quo;
	logic [WIDTH_W-1:0]        left_after;
	logic [RUN_W-1:0]          cnt_nxt;
	logic                      more_out;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign last_ch  = (CHAN_W'(ch_q) + 1'b1) == cfg.channels;

	// shared multiply-add: weight times pixel into the channel's sum
	always_comb begin
		mul_sel    = (state_q == ST_REM) ? left_q : span_q;
		prod       = mul_sel * px_q[ch_q];
		mac        = SUM_W'(sums_q[ch_q] + prod[SUM_W-1:0]);
		left_after = left_q - span_q;
		cnt_nxt    = cnt_q + 1'b1;
		more_out   = (left_after >= cfg.src_width) && (cnt_nxt < RUN_W'(MAX_RUN));
	end

	hrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MAC),
		.dividend (mac),
		.divisor  (cfg.src_width),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			cnt_q   <= '0;
			span_q  <= WIDTH_W'(1);
			sums_q  <= '0;
		end else if (restart.go) begin
			state_q <= ST_IDLE;
			span_q  <= restart.src_width;
			for (int i = 0; i < NUM_CH; i++) begin
				sums_q[i] <= SUM_W'(restart.src_width >> 1);
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && cfg.ok) begin
						cnt_q   <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					ch_q <= '0;
					if (left_q >= span_q && cnt_q < RUN_W'(MAX_RUN)) begin
						state_q <= ST_MAC;
					end else if (left_q != '0) begin
						state_q <= ST_REM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAC: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						sums_q[ch_q] <= SUM_W'(cfg.src_width >> 1);
						if (last_ch) begin
							state_q <= ST_EMIT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_EMIT: begin
					// hold until the output register can take the request
					if (out_free) begin
						span_q  <= cfg.src_width;
						cnt_q   <= cnt_nxt;
						state_q <= ST_DECIDE;
					end
				end
				ST_REM: begin
					sums_q[ch_q] <= mac;
					if (last_ch) begin
						span_q  <= span_q - left_q;
						state_q <= ST_IDLE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= in_pix;
			left_q <= cfg.dst_width;
		end else if (state_q == ST_EMIT && out_free) begin
			left_q <= left_after;
		end
		if (state_q == ST_DECIDE) begin
			res_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			res_q[ch_q] <= div_quo;
		end
	end

	always_comb begin
		emit.valid = (state_q == ST_EMIT) && out_free;
		emit.last  = !more_out;
		emit.ch    = res_q;
	end
endmodule
`default_nettype wire

// ===== design/horizontal_area_resampler_unit.sv =====
// Horizontal area resampler: top level with registers, output stage and checks.
//
// Rescales one image line from src_width to dst_width pixels by area averaging.
// Channels: the input channel carries one source pixel (in_ch0..in_ch3) per request,
// accepted when in_valid is high and in_stall low. The output channel carries one
// result pixel per request with last_of_run marking the final result caused by an
// input pixel; it is taken when out_valid is high and out_stall low. Registers
// are written on the cfg channel (index 0 src_width, 1 dst_width, 2 channels) when
// cfg_valid and cfg_ready are high; each write to one of them restarts the line.
// Timing: one multiply-add unit and one divider (two quotient bits per cycle) are
// shared by all channels, which take them in turn. Each result takes a multiply-add
// and a division per channel, the remainder of a pixel that opens a new span takes
// one more multiply-add per channel. in_stall stays high while a pixel is in work.
// Reset clears the line state to its start (src_width = dst_width = channels = 1).
// A stalled result holds in the output register; the unit finishes the next one
// and waits until the register frees up. Inputs under an invalid configuration
// are taken and dropped.
`default_nettype none
`include "assert_macros.svh"
module horizontal_area_resampler_unit import hrs_pkg::*; #(
	parameter int MAX_RUN = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WIDTH_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PIX_W-1:0]     in_ch0,
	input  wire logic [PIX_W-1:0]     in_ch1,
	input  wire logic [PIX_W-1:0]     in_ch2,
	input  wire logic [PIX_W-1:0]     in_ch3,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [PIX_W-1:0]          out_ch0,
	output logic [PIX_W-1:0]          out_ch1,
	output logic [PIX_W-1:0]          out_ch2,
	output logic [PIX_W-1:0]          out_ch3,
	output logic                      last_of_run
);
	logic [WIDTH_W-1:0] src_q;
	logic [WIDTH_W-1:0] dst_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               cfg_wr;
	logic [31:0]        run_lim;
	cfg_t               cfg;
	restart_t           restart;
	pix_vec_t           in_pix;
	result_t            emit;
	logic               out_free;
	logic               out_valid_q;
	logic               out_last_q;
	pix_vec_t           out_ch_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= WIDTH_W'(1);
			dst_q  <= WIDTH_W'(1);
			chan_q <= CHAN_W'(1);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_SRC_WIDTH: src_q  <= cfg_data;
				CFG_DST_WIDTH: dst_q  <= cfg_data;
				CFG_CHANNELS:  chan_q <= cfg_data[CHAN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		run_lim = 32'(src_q) * 32'(MAX_RUN);
		cfg.src_width = src_q;
		cfg.dst_width = dst_q;
		cfg.channels  = chan_q;
		cfg.ok = (src_q != '0) && (32'(src_q) <= 32'(MAX_WIDTH))
			&& (dst_q != '0) && (32'(dst_q) <= 32'(MAX_WIDTH))
			&& (chan_q != '0) && (32'(chan_q) <= 32'(MAX_CHANNELS))
			&& (32'(dst_q) <= run_lim);
		// restart uses the register contents as they stand after this write
		restart.go = cfg_wr && (cfg_index == CFG_SRC_WIDTH || cfg_index == CFG_DST_WIDTH
			|| cfg_index == CFG_CHANNELS);
		restart.src_width = (cfg_index == CFG_SRC_WIDTH) ? cfg_data : src_q;
	end

	assign in_pix = {in_ch3, in_ch2, in_ch1, in_ch0};

	hrs_seq #(
		.MAX_RUN (MAX_RUN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.in_valid (in_valid),
		.in_pix   (in_pix),
		.in_stall (in_stall),
		.out_free (out_free),
		.emit     (emit)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_ch_q   <= emit.ch;
			out_last_q <= emit.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_ch0     = out_ch_q[0];
	assign out_ch1     = out_ch_q[1];
	assign out_ch2     = out_ch_q[2];
	assign out_ch3     = out_ch_q[3];
	assign last_of_run = out_last_q;

	`HRS_ASSERT_SAME(a_emit_slot_free, emit.valid, !out_valid_q || !out_stall)
	`HRS_ASSERT_SAME(a_no_emit_when_idle, !in_stall, !emit.valid)
	`HRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && cfg.ok && !restart.go,
		in_stall)
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench of the horizontal area resampler: directed and random lines checked against a line model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hrs_pkg::*;

	localparam int RUN_LIMIT = 64;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 300;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WIDTH_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] in_ch0 = '0;
	logic [PIX_W-1:0] in_ch1 = '0;
	logic [PIX_W-1:0] in_ch2 = '0;
	logic [PIX_W-1:0] in_ch3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] out_ch0;
	logic [PIX_W-1:0] out_ch1;
	logic [PIX_W-1:0] out_ch2;
	logic [PIX_W-1:0] out_ch3;
	logic last_of_run;

	// line model state
	logic [WIDTH_W-1:0] line_src = 1;
	logic [WIDTH_W-1:0] line_dst = 1;
	logic [CHAN_W-1:0] line_chans = 1;
	logic [SUM_W-1:0] chan_acc [NUM_CH];
	logic [WIDTH_W-1:0] span_left;
	result_t expected_pixels [$];

	int fail_count = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	horizontal_area_resampler_unit #(.MAX_RUN(RUN_LIMIT)) dut (.*);

	always #5ns clk = ~clk;

	function automatic void restart_line();
		int i;
		for (i = 0; i < NUM_CH; i++)
			chan_acc[i] = SUM_W'(line_src >> 1);
		span_left = line_src;
	endfunction

	function automatic bit line_config_ok();
		return int'(line_src) != 0 && int'(line_src) <= MAX_WIDTH
			&& int'(line_dst) != 0 && int'(line_dst) <= MAX_WIDTH
			&& int'(line_chans) != 0 && int'(line_chans) <= MAX_CHANNELS
			&& int'(line_dst) <= RUN_LIMIT * int'(line_src);
	endfunction

	// Add one source pixel to the line and queue every output pixel it completes.
	function automatic void resample_pixel(input pix_vec_t px);
		int left;
		int count;
		int s;
		int i;
		result_t r;
		if (!line_config_ok())
			return;
		left = int'(line_dst);
		count = 0;
		while (left >= int'(span_left) && count < RUN_LIMIT) begin
			r = '0;
			r.valid = 1'b1;
			for (i = 0; i < NUM_CH; i++) begin
				if (i < int'(line_chans)) begin
					s = (int'(chan_acc[i]) + int'(span_left) * int'(px[i])) & ((1 << SUM_W) - 1);
					r.ch[i] = PIX_W'(s / int'(line_src));
					chan_acc[i] = SUM_W'(line_src >> 1);
				end
			end
			expected_pixels.push_back(r);
			left -= int'(span_left);
			span_left = line_src;
			count++;
		end
		if (left > 0) begin
			for (i = 0; i < NUM_CH; i++) begin
				if (i < int'(line_chans))
					chan_acc[i] = SUM_W'(int'(chan_acc[i]) + left * int'(px[i]));
			end
			span_left = WIDTH_W'(int'(span_left) - left);
		end
		if (count > 0)
			expected_pixels[expected_pixels.size() - 1].last = 1'b1;
	endfunction

	function automatic pix_vec_t random_pixel();
		pix_vec_t px;
		int i;
		int r;
		for (i = 0; i < NUM_CH; i++) begin
			r = $urandom_range(9);
			if (r == 0)
				px[i] = 8'h00;
			else if (r == 1)
				px[i] = 8'hff;
			else
				px[i] = PIX_W'($urandom_range(255));
		end
		return px;
	endfunction

	task automatic send_pixel(input pix_vec_t px);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_ch0 <= px[0];
		in_ch1 <= px[1];
		in_ch2 <= px[2];
		in_ch3 <= px[3];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		resample_pixel(px);
	endtask

	// Drop valid, wait for every pending output, then let the last pixel finish.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= WIDTH_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SRC_WIDTH: line_src = WIDTH_W'(value);
			CFG_DST_WIDTH: line_dst = WIDTH_W'(value);
			CFG_CHANNELS: line_chans = CHAN_W'(value);
			default: ;
		endcase
		if (idx != CFG_SPARE)
			restart_line();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_line(input int src, input int dst, input int chans);
		drain();
		write_reg(CFG_SRC_WIDTH, src);
		write_reg(CFG_DST_WIDTH, dst);
		write_reg(CFG_CHANNELS, chans);
	endtask

	task automatic test_reset_state();
		send_pixel('0);
		send_pixel({NUM_CH{8'hff}});
		drain();
	endtask

	task automatic test_scale_extremes();
		set_line(1, 64, 4);
		send_pixel({NUM_CH{8'hff}});
		send_pixel(random_pixel());
		set_line(4096, 4096, 4);
		send_pixel('0);
		send_pixel({NUM_CH{8'hff}});
		// long downscale: no pixel completes an output
		set_line(4096, 1, 2);
		send_pixel(random_pixel());
		send_pixel({NUM_CH{8'hff}});
		set_line(3, 7, 3);
		repeat (3) send_pixel(random_pixel());
		set_line(7, 3, 1);
		repeat (2) send_pixel(random_pixel());
		drain();
	endtask

	task automatic test_rejected_setups();
		int bad_src [9] = '{0, 4097, 8191, 5, 5, 5, 5, 5, 2};
		int bad_dst [9] = '{5, 5, 5, 0, 4097, 5, 5, 5, 129};
		int bad_chans [9] = '{4, 4, 4, 4, 4, 0, 5, 7, 4};
		int i;
		for (i = 0; i < 9; i++) begin
			set_line(bad_src[i], bad_dst[i], bad_chans[i]);
			send_pixel(random_pixel());
		end
		// a write to the spare index must leave the line where it was
		set_line(5, 3, 4);
		repeat (2) send_pixel(random_pixel());
		drain();
		write_reg(CFG_SPARE, 8191);
		repeat (2) send_pixel(random_pixel());
		drain();
	endtask

	task automatic test_random_lines();
		int gap_send [3] = '{27, 63, 0};
		int gap_recv [3] = '{63, 27, 0};
		int phase;
		int sent;
		int pick;
		int src;
		int dst;
		int n;
		for (phase = 0; phase < 3; phase++) begin
			send_gap_pct = gap_send[phase];
			recv_gap_pct = gap_recv[phase];
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				pick = $urandom_range(99);
				if (pick < 5) begin
					// rejected setup: pixels are dropped
					set_line($urandom_range(1, 4), $urandom_range(257, 4096), $urandom_range(1, 4));
					repeat (2) send_pixel(random_pixel());
					continue;
				end
				if (pick < 15) begin
					src = $urandom_range(1, 8);
					dst = $urandom_range(32 * src, 64 * src);
					n = 2;
				end else if (pick < 30) begin
					src = $urandom_range(64, 4096);
					dst = $urandom_range(1, src);
					n = $urandom_range(10, 30);
				end else begin
					src = $urandom_range(1, 16);
					dst = $urandom_range(1, 3 * src);
					n = src * $urandom_range(1, 3);
				end
				set_line(src, dst, $urandom_range(1, 4));
				repeat (n) send_pixel(random_pixel());
				sent += n;
			end
		end
	endtask

	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_line(2, 9, 4);
		hold_reqs++;
		repeat (20) send_pixel(random_pixel());
		drain();
		repeat (10) send_pixel(random_pixel());
		drain();
	endtask

	// output side: random stalls plus a long hold on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin : check_results
		pix_vec_t got;
		result_t want;
		int i;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_ch3, out_ch2, out_ch1, out_ch0};
			if (expected_pixels.size() == 0) begin
				$error("output pixel with none pending: out_ch0 %0d", out_ch0);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				for (i = 0; i < NUM_CH; i++) begin
					if (got[i] !== want.ch[i]) begin
						$error("out_ch%0d expected %0d got %0d", i, want.ch[i], got[i]);
						fail_count++;
					end
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run expected %0d got %0d", want.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	initial begin
		restart_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 27;
		recv_gap_pct = 63;
		test_reset_state();
		test_scale_extremes();
		test_rejected_setups();
		test_random_lines();
		test_backpressure();
		drain();
		if (fail_count == 0 && expected_pixels.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#100ms;
		$display("tb_top NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/hrs_pkg.sv
design/hrs_div.sv
design/hrs_seq.sv
design/horizontal_area_resampler_unit.sv
test/tb_top.sv
